@@ hw/rtl/hsu_pkg.sv @@
// ----------------------------------------------------------------------------
// hsu_pkg
// Shared types, constants and the hex character mapping for the septet
// unpacker.
// ----------------------------------------------------------------------------
package hsu_pkg;

    localparam int CHAR_W    = 8;
    localparam int SEPTET_W  = 7;
    localparam int PHASE_W   = 3;

    localparam logic [CHAR_W-1:0]  CHAR_BASE   = 8'h30;
    localparam logic [CHAR_W-1:0]  ALPHA_GAP   = 8'd7;
    localparam logic [CHAR_W-1:0]  DIGIT_MAX   = 8'd9;
    localparam logic [CHAR_W-1:0]  NIBBLE_MAX  = 8'h0f;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd6;

    typedef struct packed {
        logic [CHAR_W-1:0] high_char;
        logic [CHAR_W-1:0] low_char;
        logic              message_end;
    } hsu_item_t;

    typedef struct packed {
        logic [SEPTET_W-1:0] septet_first;
        logic [SEPTET_W-1:0] septet_second;
        logic                bad_digit;
        logic                two_results;
        logic [PHASE_W-1:0]  phase_next;
        logic [CHAR_W-1:0]   prev_next;
    } hsu_dec_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hsu_nibble_t;

    // Non-hex characters ':'..'@' also map into range; kept on purpose.
    function automatic hsu_nibble_t map_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        hsu_nibble_t       r;
        v = c - CHAR_BASE;
        if (v > DIGIT_MAX)
        begin
            v = v - ALPHA_GAP;
        end
        r.ok     = (v <= NIBBLE_MAX);
        r.nibble = v[3:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/hsu_if.sv @@
// ----------------------------------------------------------------------------
// hsu_if
// Valid/ready channels for hex character pairs in and septets out.
// ----------------------------------------------------------------------------
interface hsu_in_if;
    logic                      valid;
    logic                      ready;
    logic [hsu_pkg::CHAR_W-1:0] high_char;
    logic [hsu_pkg::CHAR_W-1:0] low_char;
    logic                      message_end;

    modport source (output valid, output high_char, output low_char,
                    output message_end, input ready);
    modport sink   (input valid, input high_char, input low_char,
                    input message_end, output ready);
endinterface

interface hsu_out_if;
    logic                         valid;
    logic                         ready;
    logic [hsu_pkg::SEPTET_W-1:0] septet;
    logic                         bad_digit;
    logic                         run_last;

    modport source (output valid, output septet, output bad_digit,
                    output run_last, input ready);
    modport sink   (input valid, input septet, input bad_digit,
                    input run_last, output ready);
endinterface

@@ hw/rtl/hex_septet_unpacker.sv @@
// ----------------------------------------------------------------------------
// hex_septet_unpacker
// Unpacks 7-bit packed octets, each given as two ASCII hex characters,
// into septets.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one octet per item: high_char, low_char, message_end.
//   out_ch gives septet, bad_digit and run_last; run_last marks the final
//   result of an input item.
//   An item passes the input register, then the result register, before
//   its first result is shown.
//   Throughput: one item per cycle while out_ch is ready. Every seventh
//   octet of a run yields a second septet, which holds the result register
//   while it is sent, so no item leaves the input register meanwhile.
//   A bad character gives one result with bad_digit set and restarts the
//   phase; message_end restarts it after the item.
//   Reset clears phase, previous octet and all valid flags.
//   When out_ch stalls, the input register still takes one more item,
//   then in_ch.ready drops until the result register frees up.
// ----------------------------------------------------------------------------
module hex_septet_unpacker
(
    input  logic            clk,
    input  logic            rst_n,
    hsu_in_if.sink          in_ch,
    hsu_out_if.source       out_ch
);
    import hsu_pkg::*;

    // input register
    logic               s1_valid_reg;
    hsu_item_t          s1_item_reg;

    // running state
    logic [PHASE_W-1:0] phase_reg;
    logic [CHAR_W-1:0]  prev_reg;

    // result register plus a slot for the second septet
    logic                out_valid_reg;
    logic [SEPTET_W-1:0] out_septet_reg;
    logic                out_bad_reg;
    logic                out_last_reg;
    logic                extra_valid_reg;
    logic [SEPTET_W-1:0] extra_septet_reg;

    hsu_dec_t dec;
    logic     in_fire;
    logic     out_fire;
    logic     can_load;
    logic     s1_move;

    hsu_decode u_decode
    (
        .item       (s1_item_reg),
        .phase      (phase_reg),
        .prev_octet (prev_reg),
        .dec        (dec)
    );

    assign out_fire = out_valid_reg && out_ch.ready;
    assign can_load = !extra_valid_reg && (!out_valid_reg || out_ch.ready);
    assign s1_move  = s1_valid_reg && can_load;
    assign in_ch.ready = !s1_valid_reg || can_load;
    assign in_fire  = in_ch.valid && in_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.septet    = out_septet_reg;
    assign out_ch.bad_digit = out_bad_reg;
    assign out_ch.run_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            extra_valid_reg <= 1'b0;
            phase_reg       <= PHASE_FIRST;
            prev_reg        <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg   <= 1'b1;
                extra_valid_reg <= dec.two_results;
                phase_reg       <= dec.phase_next;
                prev_reg        <= dec.prev_next;
            end
            else if (out_fire)
            begin
                out_valid_reg   <= extra_valid_reg;
                extra_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.high_char   <= in_ch.high_char;
            s1_item_reg.low_char    <= in_ch.low_char;
            s1_item_reg.message_end <= in_ch.message_end;
        end

        if (s1_move)
        begin
            out_septet_reg   <= dec.septet_first;
            out_bad_reg      <= dec.bad_digit;
            out_last_reg     <= !dec.two_results;
            extra_septet_reg <= dec.septet_second;
        end
        else if (out_fire && extra_valid_reg)
        begin
            out_septet_reg <= extra_septet_reg;
            out_bad_reg    <= 1'b0;
            out_last_reg   <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_extra_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        extra_valid_reg |-> out_valid_reg)
        else $error("second septet pending without a first");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_LAST)
        else $error("phase out of range");

    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |->
            (out_last_reg && out_septet_reg == '0 && !extra_valid_reg))
        else $error("bad digit result malformed");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        extra_valid_reg |-> !out_last_reg)
        else $error("first of two results marked last");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && extra_valid_reg) |=> (out_valid_reg && out_last_reg))
        else $error("second septet not presented");

endmodule

@@ hw/rtl/hsu_decode.sv @@
// ----------------------------------------------------------------------------
// hsu_decode
// Maps one character pair to an octet and forms the septet(s) for the
// current phase, plus the next phase and previous octet.
// ----------------------------------------------------------------------------
module hsu_decode
(
    input  hsu_pkg::hsu_item_t              item,
    input  logic [hsu_pkg::PHASE_W-1:0]     phase,
    input  logic [hsu_pkg::CHAR_W-1:0]      prev_octet,
    output hsu_pkg::hsu_dec_t               dec
);
    import hsu_pkg::*;

    hsu_nibble_t         hi;
    hsu_nibble_t         lo;
    logic [CHAR_W-1:0]   octet;
    logic [2*CHAR_W-1:0] joined;
    logic [3:0]          shamt;

    always_comb
    begin
        hi     = map_digit(item.high_char);
        lo     = map_digit(item.low_char);
        octet  = {hi.nibble, lo.nibble};
        // (b << p) | (prev >> (8 - p)) is a window of {b, prev}
        joined = {octet, prev_octet};
        shamt  = 4'(CHAR_W) - {1'b0, phase};

        dec.bad_digit     = !(hi.ok && lo.ok);
        dec.septet_first  = SEPTET_W'(joined >> shamt);
        dec.septet_second = octet[CHAR_W-1:1];
        dec.two_results   = 1'b0;
        dec.phase_next    = phase + 3'd1;
        dec.prev_next     = octet;

        if (dec.bad_digit)
        begin
            dec.septet_first = '0;
            dec.phase_next   = PHASE_FIRST;
            dec.prev_next    = '0;
        end
        else if (phase == PHASE_LAST)
        begin
            dec.two_results = 1'b1;
            dec.phase_next  = PHASE_FIRST;
        end

        if (item.message_end)
        begin
            dec.phase_next = PHASE_FIRST;
            dec.prev_next  = '0;
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hex_septet_unpacker. A short table of hand-picked
// octets runs first, then random hex messages with some noise characters, under
// three idle patterns on the two channels. Every accepted octet is run through
// a local septet unpacker, and each result leaving the block is checked in
// order against it, or against the typed expectation of a table row.
// ----------------------------------------------------------------------------
module tb;

    import hsu_pkg::*;

    localparam int HOLD_CYCLES     = 48;
    localparam int ITEMS_PER_ROUND = 150;
    localparam int NUM_DIRECTED    = 19;

    typedef struct packed {
        logic [SEPTET_W-1:0] septet;
        logic                bad_digit;
        logic                run_last;
    } unpacked_char_t;

    // high, low, end, typed expectation flag, typed septet, typed bad_digit
    typedef struct packed {
        logic [CHAR_W-1:0]   high_char;
        logic [CHAR_W-1:0]   low_char;
        logic                message_end;
        logic                typed;
        logic [SEPTET_W-1:0] septet;
        logic                bad_digit;
    } octet_row_t;

    logic clk;
    logic rst_n;

    hsu_in_if  in_bus ();
    hsu_out_if out_bus ();

    hex_septet_unpacker dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    logic [PHASE_W-1:0] septet_phase;
    logic [CHAR_W-1:0]  last_octet;
    unpacked_char_t     pending_chars [$];
    int                 failures;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 hold_requests;

    octet_row_t directed_rows [NUM_DIRECTED] = '{
        '{"F", "F", 1'b1, 1'b1, 7'h7f, 1'b0},   // all ones, then end of message
        '{"0", "0", 1'b0, 1'b1, 7'h00, 1'b0},
        '{"G", "0", 1'b0, 1'b1, 7'h00, 1'b1},   // first letter past F
        '{"/", "0", 1'b0, 1'b1, 7'h00, 1'b1},   // just below '0'
        '{"0", 8'h00, 1'b0, 1'b1, 7'h00, 1'b1},
        '{8'hff, "9", 1'b0, 1'b1, 7'h00, 1'b1},
        '{"a", "1", 1'b0, 1'b1, 7'h00, 1'b1},   // lowercase is rejected
        '{":", "?", 1'b0, 1'b0, 7'h00, 1'b0},   // punctuation that maps in range
        '{"@", "A", 1'b1, 1'b0, 7'h00, 1'b0},
        '{"E", "8", 1'b0, 1'b0, 7'h00, 1'b0},   // full seven-octet round
        '{"3", "2", 1'b0, 1'b0, 7'h00, 1'b0},
        '{"9", "B", 1'b0, 1'b0, 7'h00, 1'b0},
        '{"F", "D", 1'b0, 1'b0, 7'h00, 1'b0},
        '{"4", "6", 1'b0, 1'b0, 7'h00, 1'b0},
        '{"9", "7", 1'b0, 1'b0, 7'h00, 1'b0},
        '{"D", "9", 1'b1, 1'b0, 7'h00, 1'b0},   // two septets, end on same item
        '{"1", "2", 1'b0, 1'b0, 7'h00, 1'b0},
        '{"3", "Z", 1'b1, 1'b1, 7'h00, 1'b1},   // bad digit mid-run with end
        '{"E", "C", 1'b0, 1'b0, 7'h00, 1'b0}
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // bit 4 set: not a usable digit
    function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = c - CHAR_BASE;
        if (v >= 8'd10)
        begin
            v = v - 8'd7;
        end
        return {(v[7:4] != 4'd0), v[3:0]};
    endfunction

    function automatic int unpack_octet(input logic [CHAR_W-1:0] hc,
                                        input logic [CHAR_W-1:0] lc,
                                        input logic me,
                                        output unpacked_char_t first,
                                        output unpacked_char_t second);
        logic [4:0]  hi;
        logic [4:0]  lo;
        logic [7:0]  octet;
        logic [15:0] joined;
        int          n;
        hi = hex_value(hc);
        lo = hex_value(lc);
        first  = '0;
        second = '0;
        if (hi[4] || lo[4])
        begin
            first.bad_digit = 1'b1;
            first.run_last  = 1'b1;
            septet_phase = '0;
            last_octet   = '0;
            return 1;
        end
        octet  = {hi[3:0], lo[3:0]};
        joined = ({8'h00, octet} << septet_phase)
               | ({8'h00, last_octet} >> (8 - septet_phase));
        first.septet = joined[6:0];
        if (septet_phase == PHASE_LAST)
        begin
            second.septet   = octet[7:1];
            second.run_last = 1'b1;
            septet_phase    = '0;
            n = 2;
        end
        else
        begin
            first.run_last = 1'b1;
            septet_phase   = septet_phase + 3'd1;
            n = 1;
        end
        last_octet = octet;
        if (me)
        begin
            septet_phase = '0;
            last_octet   = '0;
        end
        return n;
    endfunction

    function automatic void log_failure(input string what);
        failures++;
        if (failures <= 10)
        begin
            $display("%0t  %s", $time, what);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] pick_hex_char();
        int k;
        k = $urandom_range(0, 22);
        if (k < 10)
        begin
            return CHAR_W'(8'h30 + k);
        end
        if (k < 16)
        begin
            return CHAR_W'(8'h41 + (k - 10));
        end
        return CHAR_W'(8'h3a + (k - 16));    // ':' .. '@'
    endfunction

    task automatic offer_octet(input logic [CHAR_W-1:0] hc, input logic [CHAR_W-1:0] lc,
                               input logic me, input logic typed,
                               input unpacked_char_t typed_char);
        unpacked_char_t r0;
        unpacked_char_t r1;
        int             n;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.high_char   <= hc;
        in_bus.low_char    <= lc;
        in_bus.message_end <= me;
        do
            @(posedge clk);
        while (!in_bus.ready);
        n = unpack_octet(hc, lc, me, r0, r1);
        if (typed)
        begin
            pending_chars.push_back(typed_char);
        end
        else
        begin
            pending_chars.push_back(r0);
            if (n == 2)
            begin
                pending_chars.push_back(r1);
            end
        end
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chars.size() != 0);
    endtask

    // receiver: random ready, plus long hold-offs on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        unpacked_char_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                log_failure($sformatf("unexpected item: septet %h bad %b last %b",
                            out_bus.septet, out_bus.bad_digit, out_bus.run_last));
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_bus.septet !== want.septet || out_bus.bad_digit !== want.bad_digit
                    || out_bus.run_last !== want.run_last)
                begin
                    log_failure($sformatf({"mismatch: septet %h/%h bad %b/%b last %b/%b",
                                " (exp/got)"}, want.septet, out_bus.septet, want.bad_digit,
                                out_bus.bad_digit, want.run_last, out_bus.run_last));
                end
            end
        end
    end

    initial
    begin
        int             src_pcts [3];
        int             sink_pcts [3];
        int             msg_left;
        logic [7:0]     hc;
        logic [7:0]     lc;
        logic           me;
        unpacked_char_t typed_char;
        src_pcts  = '{20, 58, 0};
        sink_pcts = '{58, 20, 0};
        clk           = 1'b0;
        failures      = 0;
        hold_requests = 0;
        septet_phase  = '0;
        last_octet    = '0;
        src_idle_pct  = src_pcts[0];
        sink_idle_pct = sink_pcts[0];
        msg_left      = 0;
        rst_n              <= 1'b0;
        in_bus.valid       <= 1'b0;
        in_bus.high_char   <= '0;
        in_bus.low_char    <= '0;
        in_bus.message_end <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_char.septet    = directed_rows[i].septet;
            typed_char.bad_digit = directed_rows[i].bad_digit;
            typed_char.run_last  = 1'b1;
            offer_octet(directed_rows[i].high_char, directed_rows[i].low_char,
                        directed_rows[i].message_end, directed_rows[i].typed, typed_char);
        end
        wait_drained();

        typed_char = '0;
        for (int round = 0; round < 3; round++)
        begin
            src_idle_pct  = src_pcts[round];
            sink_idle_pct = sink_pcts[round];
            for (int i = 0; i < ITEMS_PER_ROUND; i++)
            begin
                // receiver blocks while octets keep coming, so the block backs up
                if (round < 2 && i == 60)
                begin
                    hold_requests++;
                end
                if (msg_left == 0)
                begin
                    msg_left = $urandom_range(1, 24);
                end
                hc = pick_hex_char();
                lc = pick_hex_char();
                if ($urandom_range(99) < 12)
                begin
                    if ($urandom_range(1))
                    begin
                        hc = CHAR_W'($urandom_range(255));
                    end
                    else
                    begin
                        lc = CHAR_W'($urandom_range(255));
                    end
                end
                me = (msg_left == 1) || ($urandom_range(99) < 3);
                msg_left--;
                offer_octet(hc, lc, me, 1'b0, typed_char);
            end
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (failures == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
